// File: rtl/core/hll_pkg.sv
// ----------------------------------------------------------------------------
// hll_pkg: shared types and constants for the HTML highlight lexer
// Character codes, color classes and the byte classification struct.
// ----------------------------------------------------------------------------
package hll_pkg;

    // Widths of the stream words
    localparam int unsigned CH_W     = 8;
    localparam int unsigned NVALID_W = 2;
    localparam int unsigned IN_W     = 40;  // 4 bytes + 2 bits, padded to bytes
    localparam int unsigned COLOR_W  = 3;
    localparam int unsigned OUT_W    = 8;

    // Character codes
    localparam logic [CH_W-1:0] CH_LT     = 8'h3C;  // <
    localparam logic [CH_W-1:0] CH_GT     = 8'h3E;  // >
    localparam logic [CH_W-1:0] CH_EQ     = 8'h3D;  // =
    localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;  // /
    localparam logic [CH_W-1:0] CH_DASH   = 8'h2D;  // -
    localparam logic [CH_W-1:0] CH_UNDER  = 8'h5F;  // _
    localparam logic [CH_W-1:0] CH_BANG   = 8'h21;  // !
    localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;  // backslash
    localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_CR     = 8'h0D;

    // Lookahead counts
    localparam logic [NVALID_W-1:0] NVALID_ONE   = 2'd1;
    localparam logic [NVALID_W-1:0] NVALID_THREE = 2'd3;

    // Color classes
    typedef enum logic [COLOR_W-1:0] {
        COL_DEFAULT  = 3'd0,
        COL_SYMBOL   = 3'd1,
        COL_KEYWORD  = 3'd2,
        COL_FUNCTION = 3'd3,
        COL_STRING   = 3'd4,
        COL_COMMENT  = 3'd5
    } t_color;

    // Flags derived from the current byte and its lookahead
    typedef struct packed {
        logic is_word;     // letter, digit, '_' or '-'
        logic is_blank;    // C isspace
        logic is_quote;    // single or double quote
        logic is_lt;
        logic is_gt;
        logic is_eq;
        logic is_slash;
        logic is_bslash;
        logic cmt_open;    // "<!--" with all three lookahead bytes valid
        logic cmt_dash2;   // "--" with at least one valid lookahead byte
    } t_byte_cls;

endpackage

// File: rtl/core/hll_byte_class.sv
// ----------------------------------------------------------------------------
// hll_byte_class: character classification
// Decodes the current byte and its lookahead into a flag struct.
// ----------------------------------------------------------------------------
module hll_byte_class (
    input  logic [hll_pkg::CH_W-1:0]     i_ch,
    input  logic [hll_pkg::CH_W-1:0]     i_ahead_one,
    input  logic [hll_pkg::CH_W-1:0]     i_ahead_two,
    input  logic [hll_pkg::CH_W-1:0]     i_ahead_three,
    input  logic [hll_pkg::NVALID_W-1:0] i_ahead_valid,
    output hll_pkg::t_byte_cls           o_cls
);

    logic w_lower;
    logic w_upper;
    logic w_digit;

    assign w_lower = (i_ch >= 8'h61) && (i_ch <= 8'h7A);
    assign w_upper = (i_ch >= 8'h41) && (i_ch <= 8'h5A);
    assign w_digit = (i_ch >= 8'h30) && (i_ch <= 8'h39);

    always_comb begin
        o_cls.is_word   = w_lower || w_upper || w_digit ||
                          (i_ch == hll_pkg::CH_UNDER) || (i_ch == hll_pkg::CH_DASH);
        o_cls.is_blank  = (i_ch == hll_pkg::CH_SPACE) ||
                          ((i_ch >= hll_pkg::CH_TAB) && (i_ch <= hll_pkg::CH_CR));
        o_cls.is_quote  = (i_ch == hll_pkg::CH_DQUOTE) || (i_ch == hll_pkg::CH_SQUOTE);
        o_cls.is_lt     = (i_ch == hll_pkg::CH_LT);
        o_cls.is_gt     = (i_ch == hll_pkg::CH_GT);
        o_cls.is_eq     = (i_ch == hll_pkg::CH_EQ);
        o_cls.is_slash  = (i_ch == hll_pkg::CH_SLASH);
        o_cls.is_bslash = (i_ch == hll_pkg::CH_BSLASH);
        o_cls.cmt_open  = (i_ch == hll_pkg::CH_LT) &&
                          (i_ahead_valid == hll_pkg::NVALID_THREE) &&
                          (i_ahead_one == hll_pkg::CH_BANG) &&
                          (i_ahead_two == hll_pkg::CH_DASH) &&
                          (i_ahead_three == hll_pkg::CH_DASH);
        o_cls.cmt_dash2 = (i_ch == hll_pkg::CH_DASH) &&
                          (i_ahead_valid >= hll_pkg::NVALID_ONE) &&
                          (i_ahead_one == hll_pkg::CH_DASH);
    end

endmodule

// File: rtl/core/hll_lex_fsm.sv
// ----------------------------------------------------------------------------
// hll_lex_fsm: lexer state machine
// Holds the lexer state and the registered color class of each byte.
// ----------------------------------------------------------------------------
module hll_lex_fsm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,   // one byte moves to the result register
    input  hll_pkg::t_byte_cls   i_cls,
    output hll_pkg::t_color      o_color
);

    typedef enum logic [3:0] {
        LX_DEFAULT    = 4'd0,
        LX_TAG_OPEN   = 4'd1,
        LX_TAG_NAME   = 4'd2,
        LX_ATTR_NAME  = 4'd3,
        LX_ATTR_VALUE = 4'd4,
        LX_TAG_CLOSE  = 4'd5,
        LX_COMMENT    = 4'd6,
        LX_CMT_EXIT1  = 4'd7,
        LX_CMT_EXIT2  = 4'd8,
        LX_STRING     = 4'd9,
        LX_STR_ESCAPE = 4'd10
    } t_lex_state;

    t_lex_state      r_state;
    t_lex_state      n_state;
    hll_pkg::t_color r_color;
    hll_pkg::t_color n_color;

    always_comb begin
        n_state = r_state;
        n_color = hll_pkg::COL_DEFAULT;
        unique case (r_state)
            LX_CMT_EXIT2: begin
                n_state = LX_DEFAULT;
                n_color = hll_pkg::COL_COMMENT;
            end
            LX_CMT_EXIT1: begin
                n_state = i_cls.is_gt ? LX_CMT_EXIT2 : LX_COMMENT;
                n_color = hll_pkg::COL_COMMENT;
            end
            LX_COMMENT: begin
                if (i_cls.cmt_dash2) begin
                    n_state = LX_CMT_EXIT1;
                end
                n_color = hll_pkg::COL_COMMENT;
            end
            LX_STR_ESCAPE: begin
                n_state = LX_STRING;
                n_color = hll_pkg::COL_STRING;
            end
            LX_STRING: begin
                if (i_cls.is_bslash) begin
                    n_state = LX_STR_ESCAPE;
                end else if (i_cls.is_quote) begin
                    n_state = LX_ATTR_NAME;
                end
                n_color = hll_pkg::COL_STRING;
            end
            LX_ATTR_VALUE: begin
                if (i_cls.is_quote) begin
                    n_state = LX_STRING;
                    n_color = hll_pkg::COL_STRING;
                end else if (i_cls.is_gt) begin
                    n_state = LX_DEFAULT;
                    n_color = hll_pkg::COL_SYMBOL;
                end else begin
                    n_state = LX_ATTR_NAME;
                end
            end
            LX_ATTR_NAME: begin
                if (i_cls.is_eq) begin
                    n_state = LX_ATTR_VALUE;
                    n_color = hll_pkg::COL_SYMBOL;
                end else if (i_cls.is_gt) begin
                    n_state = LX_DEFAULT;
                    n_color = hll_pkg::COL_SYMBOL;
                end else if (i_cls.is_word && !i_cls.is_blank) begin
                    n_color = hll_pkg::COL_FUNCTION;
                end
            end
            LX_TAG_NAME: begin
                if (i_cls.is_gt) begin
                    n_state = LX_DEFAULT;
                    n_color = hll_pkg::COL_SYMBOL;
                end else if (i_cls.is_word) begin
                    n_color = hll_pkg::COL_KEYWORD;
                end else begin
                    n_state = LX_ATTR_NAME;
                end
            end
            LX_TAG_OPEN: begin
                if (i_cls.is_word || i_cls.is_slash) begin
                    n_state = LX_TAG_NAME;
                    n_color = hll_pkg::COL_KEYWORD;
                end else begin
                    n_state = LX_DEFAULT;
                end
            end
            LX_TAG_CLOSE: begin
                n_state = LX_DEFAULT;
                n_color = hll_pkg::COL_SYMBOL;
            end
            default: begin
                // plain text, and any unused code
                if (i_cls.cmt_open) begin
                    n_state = LX_COMMENT;
                    n_color = hll_pkg::COL_COMMENT;
                end else if (i_cls.is_lt) begin
                    n_state = LX_TAG_OPEN;
                    n_color = hll_pkg::COL_SYMBOL;
                end else begin
                    n_state = LX_DEFAULT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_color <= n_color;
        end
        if (!i_rst_n) begin
            r_state <= LX_DEFAULT;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    assign o_color = r_color;

endmodule

// File: rtl/core/html_highlight_lexer.sv
// ----------------------------------------------------------------------------
// html_highlight_lexer: HTML syntax-highlighting lexer, one byte per clock unless m_axis stalls
// Classifies each text byte into a color class while tracking tag, attribute,
// string and comment context.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one text byte per word together with three lookahead bytes
//   and the count of valid lookahead bytes (0..3). m_axis returns one color
//   class per accepted word, in order: 0 default, 1 symbol, 2 keyword,
//   3 function, 4 string, 5 comment.
//   Path: an accepted word is held in the input register; its color class
//   then moves into the result register and shows on m_axis.
//   Throughput: one word per clock while m_axis is not stalled. The lexer
//   state register is updated in the same cycle that a byte moves into
//   the result register, so the next byte always sees the state left by
//   the previous one.
//   Stall: the result register holds while m_axis_tready is low; the input
//   register still takes one more word, after which s_axis_tready drops
//   until the result is taken.
//   Reset (i_rst_n low, synchronous): both stages empty, lexer state returns
//   to plain text.
// ----------------------------------------------------------------------------
module html_highlight_lexer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [7:0] ch, [15:8] ahead_one, [23:16] ahead_two, [31:24] ahead_three,
    // [33:32] ahead_valid, [39:34] zero
    input  logic [hll_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [2:0] color_class, [7:3] zero
    output logic [hll_pkg::OUT_W-1:0]   m_axis_tdata
);

    // input register
    logic                           r_in_valid;
    logic [hll_pkg::CH_W-1:0]       r_ch;
    logic [hll_pkg::CH_W-1:0]       r_ahead_one;
    logic [hll_pkg::CH_W-1:0]       r_ahead_two;
    logic [hll_pkg::CH_W-1:0]       r_ahead_three;
    logic [hll_pkg::NVALID_W-1:0]   r_ahead_valid;

    // result stage
    logic                           r_out_valid;

    logic                           w_out_free;
    logic                           w_step;
    logic                           w_in_take;
    hll_pkg::t_byte_cls             w_cls;
    hll_pkg::t_color                w_color;

    // result register frees up when empty or being taken this cycle
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_ch          <= s_axis_tdata[7:0];
            r_ahead_one   <= s_axis_tdata[15:8];
            r_ahead_two   <= s_axis_tdata[23:16];
            r_ahead_three <= s_axis_tdata[31:24];
            r_ahead_valid <= s_axis_tdata[33:32];
        end
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    hll_byte_class u_byte_class (
        .i_ch          (r_ch),
        .i_ahead_one   (r_ahead_one),
        .i_ahead_two   (r_ahead_two),
        .i_ahead_three (r_ahead_three),
        .i_ahead_valid (r_ahead_valid),
        .o_cls         (w_cls)
    );

    hll_lex_fsm u_lex_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_cls   (w_cls),
        .o_color (w_color)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(hll_pkg::OUT_W - hll_pkg::COLOR_W){1'b0}}, w_color};

endmodule

// File: rtl/core/hll_checker.sv
// ----------------------------------------------------------------------------
// hll_checker: port-level checks for the HTML highlight lexer
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module hll_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [hll_pkg::OUT_W-1:0]   m_axis_tdata
);

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // only a full pipeline with a stalled receiver pushes back
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output stall");

    // color class stays within its six codes, upper bits zero
    a_color_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata <= 8'(hll_pkg::COL_COMMENT)))
        else $error("color class out of range");

    // a stalled result holds its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // an accepted word with an idle output reaches the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (!m_axis_tvalid || m_axis_tready))
            |=> ##1 m_axis_tvalid)
        else $error("accepted word did not reach the output");

endmodule

bind html_highlight_lexer hll_checker u_hll_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
